// File: rtl/isl_pkg.sv
// shared types and constants for the indexed shift list
// no dependencies
`default_nettype none

package isl_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_SET,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [IDX_W-1:0] index;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/isl_cell.sv
// one storage cell of the list chain, shifts with its neighbors
// depends on isl_pkg
`default_nettype none

module isl_cell #(
  parameter int unsigned DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DEPTH      = isl_pkg::DEPTH_DEF,
  parameter int unsigned POS        = 0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire isl_pkg::cell_cmd_t  cmd_i,
  input  wire     [DATA_WIDTH-1:0] value_i,
  input  wire     [DATA_WIDTH-1:0] prev_i,
  input  wire     [DATA_WIDTH-1:0] next_i,
  output logic    [DATA_WIDTH-1:0] data_o,
  output logic    [DATA_WIDTH-1:0] rd_o
);

  localparam int unsigned PosW = $clog2(DEPTH);
  localparam int unsigned CmpW = (isl_pkg::IDX_W > PosW) ? isl_pkg::IDX_W : PosW;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [CmpW-1:0]       pos, idx;
  logic                  hit, above;

  assign pos   = CmpW'(POS);
  assign idx   = CmpW'(cmd_i.index);
  assign hit   = (idx == pos);
  assign above = (pos > idx);

  always_comb begin
    data_d = data_q;
    case (cmd_i.kind)
      isl_pkg::CMD_INSERT: begin
        if (above) begin
          data_d = prev_i;
        end else if (hit) begin
          data_d = value_i;
        end
      end
      isl_pkg::CMD_REMOVE: begin
        if (above || hit) begin
          data_d = next_i;
        end
      end
      isl_pkg::CMD_SET: begin
        if (hit) begin
          data_d = value_i;
        end
      end
      isl_pkg::CMD_CLEAR: data_d = '0;
      default:            data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

`default_nettype wire

// File: rtl/isl_ctrl.sv
// operation decode, entry count, bounds checks and result register
// depends on isl_pkg
`default_nettype none

module isl_ctrl #(
  parameter int unsigned DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DEPTH      = isl_pkg::DEPTH_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire     [isl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  wire     [isl_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic    [isl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic    [isl_pkg::STATUS_W-1:0]    m_axis_tuser,
  input  wire     [DATA_WIDTH-1:0]           rd_data_i,
  output isl_pkg::cell_cmd_t                 cmd_o,
  output logic    [DATA_WIDTH-1:0]           value_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (isl_pkg::IDX_W > CntW) ? isl_pkg::IDX_W : CntW;

  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            valid_q;
  logic [isl_pkg::VALUE_W-1:0]     rd_q, rd_d;
  isl_pkg::status_e                status_q, status_d;
  logic [isl_pkg::COUNT_W-1:0]     cnt_out_q;
  logic                            accept;
  logic [isl_pkg::IDX_W-1:0]       index;
  logic [CmpW-1:0]                 idx_c, cnt_c;
  logic                            full;
  isl_pkg::cmd_e                   kind;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign index   = s_axis_tdata[isl_pkg::IDX_W-1:0];
  assign value_o = DATA_WIDTH'(s_axis_tdata[isl_pkg::IDX_W +: isl_pkg::VALUE_W]);
  assign idx_c   = CmpW'(index);
  assign cnt_c   = CmpW'(cnt_q);
  assign full    = (cnt_q == CntW'(DEPTH));

  always_comb begin
    kind     = isl_pkg::CMD_HOLD;
    cnt_d    = cnt_q;
    rd_d     = '0;
    status_d = isl_pkg::ST_OK;
    case (isl_pkg::op_e'(s_axis_tuser))
      isl_pkg::OP_INSERT: begin
        if (idx_c > cnt_c) begin
          status_d = isl_pkg::ST_RANGE;
        end else if (full) begin
          status_d = isl_pkg::ST_FULL;
        end else begin
          kind  = isl_pkg::CMD_INSERT;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      isl_pkg::OP_REMOVE: begin
        if (idx_c >= cnt_c) begin
          status_d = isl_pkg::ST_RANGE;
        end else begin
          kind  = isl_pkg::CMD_REMOVE;
          rd_d  = isl_pkg::VALUE_W'(rd_data_i);
          cnt_d = cnt_q - CntW'(1);
        end
      end
      isl_pkg::OP_GET: begin
        if (idx_c >= cnt_c) begin
          status_d = isl_pkg::ST_RANGE;
        end else begin
          rd_d = isl_pkg::VALUE_W'(rd_data_i);
        end
      end
      isl_pkg::OP_SET: begin
        if (idx_c >= cnt_c) begin
          status_d = isl_pkg::ST_RANGE;
        end else begin
          kind = isl_pkg::CMD_SET;
        end
      end
      isl_pkg::OP_CLEAR: begin
        kind  = isl_pkg::CMD_CLEAR;
        cnt_d = '0;
      end
      default: kind = isl_pkg::CMD_HOLD;
    endcase
  end

  assign cmd_o.kind  = accept ? kind : isl_pkg::CMD_HOLD;
  assign cmd_o.index = index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q   <= cnt_d;
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= rd_d;
      status_q  <= status_d;
      cnt_out_q <= isl_pkg::COUNT_W'(cnt_d);
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = isl_pkg::M_TDATA_W'({cnt_out_q, rd_q});

endmodule

`default_nettype wire

// File: rtl/indexed_shift_list_top.sv
// top level of the indexed shift list: control plus a chain of storage cells
// depends on isl_pkg, isl_cell, isl_ctrl
//
// channel   dir  tdata (low bit up)                       tuser
// s_axis    in   index[4:0], item_value[36:5], zero pad   op[2:0]
// m_axis    out  read_value[31:0], count_after[36:32]     status[1:0]
//
// one transfer in, one result out; the result is registered and appears in the cycle after the
// input transfer, and a new item is taken every cycle while m_axis drains
// every cell updates in the same cycle from its neighbors, so the rate is
// set by the read select over all cells feeding the result register
// reset empties the list and zeroes all cells at once
// a stalled output holds its result and blocks input only while it is full
`default_nettype none

module indexed_shift_list_top #(
  parameter int unsigned DEPTH      = isl_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [isl_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // index, item_value
  input  wire  [isl_pkg::OP_W-1:0]          s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [isl_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // read_value, count_after
  output logic [isl_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);

  isl_pkg::cell_cmd_t    cmd;
  logic [DATA_WIDTH-1:0] value;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  isl_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .rd_data_i     (rd_data),
    .cmd_o         (cmd),
    .value_o       (value)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next = '0;
    end else begin : g_body
      assign next = cell_data[g+1];
    end

    isl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .POS        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .value_i (value),
      .prev_i  (prev),
      .next_i  (next),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/isl_checker.sv
// port-level checks for the indexed shift list, bound to the top level
// depends on isl_pkg, indexed_shift_list_top
`default_nettype none

module isl_checker #(
  parameter int unsigned DEPTH = isl_pkg::DEPTH_DEF
) (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire [isl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input wire [isl_pkg::OP_W-1:0]        s_axis_tuser,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [isl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input wire [isl_pkg::STATUS_W-1:0]    m_axis_tuser
);

  localparam logic [isl_pkg::COUNT_W-1:0] FullCount = isl_pkg::COUNT_W'(DEPTH);

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after input transfer");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked without a stalled result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != isl_pkg::ST_OK |->
      m_axis_tdata[isl_pkg::VALUE_W-1:0] == '0)
    else $error("error result carries data");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == isl_pkg::ST_FULL |->
      m_axis_tdata[isl_pkg::VALUE_W +: isl_pkg::COUNT_W] == FullCount)
    else $error("full status with list not full");

endmodule

bind indexed_shift_list_top isl_checker #(.DEPTH(DEPTH)) u_isl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: bench/indexed_shift_list_top_test.sv
// self-checking bench for indexed_shift_list_top: random and directed list operations
// with bursty input and a stalling output, each result checked against a list model
// depends on isl_pkg and indexed_shift_list_top
`timescale 1ns / 1ps

module indexed_shift_list_top_test;
  import isl_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   index;
    logic [VALUE_W-1:0] value;
    bit                 wait_drain;
  } list_cmd_t;

  typedef struct {
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count_after;
  } list_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // index, item_value, zero pad
  logic [OP_W-1:0]      s_axis_tuser = '0;  // op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // read_value, count_after
  logic [STATUS_W-1:0]  m_axis_tuser;       // status

  list_cmd_t    cmd_q[$];
  list_result_t pending_results[$];

  logic [VALUE_W-1:0] model_cells[LIST_DEPTH];
  int unsigned        model_count = 0;

  logic        in_took = 1'b0;
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned hold_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned in_transfers = 0;
  int unsigned out_transfers = 0;
  int unsigned op_seen[8];
  int unsigned range_seen = 0;
  int unsigned full_seen = 0;

  indexed_shift_list_top #(
    .DEPTH     (DEPTH_DEF),
    .DATA_WIDTH(DATA_WIDTH_DEF)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                                 logic [VALUE_W-1:0] val);
    list_result_t r;
    int unsigned  i;
    r.read_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_INSERT: begin
        if (idx > model_count) begin
          r.status = ST_RANGE;
        end else if (model_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = model_count; i > idx; i--) model_cells[i] = model_cells[i-1];
          model_cells[idx] = val;
          model_count++;
        end
      end
      OP_REMOVE: begin
        if (idx >= model_count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = model_cells[idx];
          for (i = idx + 1; i < model_count; i++) model_cells[i-1] = model_cells[i];
          model_cells[model_count-1] = '0;
          model_count--;
        end
      end
      OP_GET: begin
        if (idx >= model_count) r.status = ST_RANGE;
        else r.read_value = model_cells[idx];
      end
      OP_SET: begin
        if (idx >= model_count) r.status = ST_RANGE;
        else model_cells[idx] = val;
      end
      OP_CLEAR: begin
        for (i = 0; i < LIST_DEPTH; i++) model_cells[i] = '0;
        model_count = 0;
      end
      default: ;
    endcase
    r.count_after = model_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
    if (error_count < 50)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic queue_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] val,
                           bit wait_drain);
    list_cmd_t c;
    c.op         = op;
    c.index      = idx;
    c.value      = val;
    c.wait_drain = wait_drain;
    cmd_q.push_back(c);
  endtask

  // sender: bursts with random gaps, a held item stays until its transfer
  always @(negedge clk_i) begin : drive
    list_cmd_t nxt;
    logic      holding;
    holding = s_axis_tvalid && !in_took;
    if (rst_ni && !holding) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q[0].wait_drain && pending_results.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, nxt.value, nxt.index};
        s_axis_tuser  <= nxt.op;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: rotating stall patterns plus long hold-offs
  always @(negedge clk_i) begin : receive
    logic ready;
    ready = 1'b1;
    if (rst_ni) begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (rx_cycle == 250 || rx_cycle == 1500) begin
        hold_left = HOLD_CYCLES;
        hold_count++;
        ready = 1'b0;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: ready = 1'b1;
          1: ready = 1'($urandom_range(0, 1));
          2: ready = (rx_cycle % 3) == 0;
          default: ready = $urandom_range(0, 7) != 0;
        endcase
      end
    end
    m_axis_tready <= ready;
  end

  always @(posedge clk_i) begin : observe
    list_result_t got;
    list_result_t want;
    logic         in_fire;
    logic         out_fire;
    in_fire  = s_axis_tvalid && s_axis_tready;
    out_fire = m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (in_fire) begin
        want = apply_list_op(s_axis_tuser, s_axis_tdata[IDX_W-1:0],
                             s_axis_tdata[IDX_W +: VALUE_W]);
        pending_results.push_back(want);
        in_transfers++;
        op_seen[s_axis_tuser]++;
        if (want.status == ST_RANGE) range_seen++;
        if (want.status == ST_FULL) full_seen++;
      end
      if (out_fire) begin
        out_transfers++;
        got.read_value  = m_axis_tdata[VALUE_W-1:0];
        got.count_after = m_axis_tdata[VALUE_W +: COUNT_W];
        got.status      = m_axis_tuser;
        if (pending_results.size() == 0) begin
          report_mismatch("result with none pending", got.read_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.status !== want.status)
            report_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
          if (got.count_after !== want.count_after)
            report_mismatch("count_after", VALUE_W'(got.count_after), VALUE_W'(want.count_after));
        end
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
    in_took <= rst_ni && in_fire;
  end

  initial begin : run
    int unsigned      k;
    int unsigned      ph;
    int unsigned      n;
    int unsigned      pick;
    int unsigned      ins_w;
    int unsigned      rem_w;
    int unsigned      gen_count;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VALUE_W-1:0] val;

    for (k = 0; k < LIST_DEPTH; k++) model_cells[k] = '0;
    for (k = 0; k < 8; k++) op_seen[k] = 0;

    // empty list, insert past the end, fill to full, then full and range edges
    queue_cmd(OP_REMOVE, 5'd0, 32'h0, 1'b0);
    queue_cmd(OP_INSERT, 5'd1, 32'h1234_5678, 1'b0);
    for (k = 0; k < LIST_DEPTH; k++) begin
      idx = (k % 3 == 0) ? 5'd0 : (k % 3 == 1) ? IDX_W'(k) : IDX_W'(k / 2);
      val = (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? 32'h0 : $urandom;
      queue_cmd(OP_INSERT, idx, val, 1'b0);
    end
    queue_cmd(OP_INSERT, 5'd16, $urandom, 1'b0);
    queue_cmd(OP_INSERT, 5'd17, $urandom, 1'b0);
    queue_cmd(OP_GET, 5'd15, 32'h0, 1'b0);
    queue_cmd(OP_REMOVE, 5'd15, 32'h0, 1'b0);
    queue_cmd(OP_SET, 5'd15, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(3'd7, 5'd31, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(OP_CLEAR, 5'd31, 32'hFFFF_FFFF, 1'b0);

    // phases lean toward filling, draining, then balanced traffic
    gen_count = 0;
    for (ph = 0; ph < 4; ph++) begin
      ins_w = (ph == 0) ? 55 : (ph == 1) ? 20 : 38;
      rem_w = (ph == 1) ? 50 : (ph == 0) ? 20 : 28;
      for (n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < ins_w) op = OP_INSERT;
        else if (pick < ins_w + rem_w) op = OP_REMOVE;
        else if (pick < 93) op = $urandom_range(0, 1) ? OP_GET : OP_SET;
        else if (pick < 95) op = OP_CLEAR;
        else op = OP_W'($urandom_range(5, 7));
        if ($urandom_range(0, 7) == 0) idx = IDX_W'($urandom_range(0, 31));
        else if (op == OP_INSERT) idx = IDX_W'($urandom_range(0, gen_count));
        else idx = (gen_count == 0) ? '0 : IDX_W'($urandom_range(0, gen_count - 1));
        case ($urandom_range(0, 15))
          0: val = '0;
          1: val = '1;
          default: val = $urandom;
        endcase
        if (op == OP_INSERT && idx <= gen_count && gen_count < LIST_DEPTH) gen_count++;
        else if (op == OP_REMOVE && idx < gen_count) gen_count--;
        else if (op == OP_CLEAR) gen_count = 0;
        queue_cmd(op, idx, val, n == 0);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", VALUE_W'(pending_results.size()), '0);

    $display("covered %0d items in, %0d results out: insert %0d, remove %0d, get %0d, set %0d,",
             in_transfers, out_transfers, op_seen[OP_INSERT], op_seen[OP_REMOVE],
             op_seen[OP_GET], op_seen[OP_SET]);
    $display("clear %0d, undefined ops %0d, out of range %0d, full list %0d, output hold-offs %0d",
             op_seen[OP_CLEAR], op_seen[5] + op_seen[6] + op_seen[7], range_seen, full_seen,
             hold_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
